// ----- rtl/core/durp_pkg.sv -----
// Shared types and constants for the duration argument parser.
// Used by durp_front, durp_back and the top level; depends on nothing else.

package durp_pkg;

	// One input transaction: a character and the last-argument flag.
	typedef struct packed {
		logic [7:0] ch;
		logic       final_req;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [47:0] total_seconds;
		logic [29:0] total_nanos;
		logic [1:0]  status;
	} out_item_t;

	// Character classes produced by the front end.
	typedef enum logic [2:0] {
		TK_DIGIT,
		TK_DAY,
		TK_HOUR,
		TK_MIN,
		TK_SEC,
		TK_DOT,
		TK_BAD,
		TK_END
	} tok_kind_t;

	// Classified character as it travels through the token queue.
	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] digit;
		logic       fin;
	} token_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_SUFFIX   = 2'd2;
	localparam logic [1:0] ST_FRACTION = 2'd3;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam int          FRAC_MAX   = 9;

	// Weight in nanoseconds of the fraction digit at position idx (0 is
	// the first digit after the dot).
	function automatic logic [26:0] frac_weight(input logic [3:0] idx);
		logic [26:0] w;
		case (idx)
			4'd0:    w = 27'd100000000;
			4'd1:    w = 27'd10000000;
			4'd2:    w = 27'd1000000;
			4'd3:    w = 27'd100000;
			4'd4:    w = 27'd10000;
			4'd5:    w = 27'd1000;
			4'd6:    w = 27'd100;
			4'd7:    w = 27'd10;
			4'd8:    w = 27'd1;
			default: w = 27'd0;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/durp_front.sv -----
// Front end of the duration parser: classifies each incoming character.
// Depends on durp_pkg.

module durp_front (
	input  durp_pkg::in_item_t item,
	output durp_pkg::token_t   tok
);

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_DOT  = 8'h2e;
	localparam logic [7:0] CH_D    = 8'h64;
	localparam logic [7:0] CH_H    = 8'h68;
	localparam logic [7:0] CH_M    = 8'h6d;
	localparam logic [7:0] CH_S    = 8'h73;

	always_comb begin
		tok.digit = item.ch[3:0];
		tok.fin   = item.final_req;
		if (item.ch inside {[CH_0:CH_9]}) begin
			tok.kind = durp_pkg::TK_DIGIT;
		end else begin
			case (item.ch)
				CH_NUL:  tok.kind = durp_pkg::TK_END;
				CH_DOT:  tok.kind = durp_pkg::TK_DOT;
				CH_D:    tok.kind = durp_pkg::TK_DAY;
				CH_H:    tok.kind = durp_pkg::TK_HOUR;
				CH_M:    tok.kind = durp_pkg::TK_MIN;
				CH_S:    tok.kind = durp_pkg::TK_SEC;
				default: tok.kind = durp_pkg::TK_BAD;
			endcase
		end
	end

endmodule

// ----- rtl/core/durp_fifo.sv -----
// Small synchronous queue used between the parser stages and at the output.
// Self-contained; DEPTH must be a power of two, at least two.

module durp_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	output logic full,
	input  logic rd_en,
	output T     rd_data,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);

	T               mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    cnt_q;
	logic           wr_ok;
	logic           rd_ok;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr_ok   = wr_en && !full;
	assign rd_ok   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_ok) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({wr_ok, rd_ok})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/durp_back.sv -----
// Back end of the duration parser: runs the per-argument state machine,
// accumulates totals and produces result transactions. Depends on durp_pkg.

module durp_back #(
	parameter int SECONDS_WIDTH = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  durp_pkg::token_t    tok,
	input  logic                tok_valid,
	output logic                tok_pop,
	output logic                res_push,
	output durp_pkg::out_item_t res_data,
	input  logic                res_full
);

	localparam int SW = SECONDS_WIDTH;
	localparam int PW = SW + 17;

	typedef enum logic [1:0] {
		PH_INT,
		PH_FRAC,
		PH_SKIP,
		PH_DISCARD
	} phase_t;

	phase_t          phase_q;
	logic            at_start_q;
	logic [SW-1:0]   arg_sec_q;
	logic [29:0]     frac_ns_q;
	logic [3:0]      frac_dig_q;
	logic [SW-1:0]   sum_sec_q;
	logic [29:0]     sum_ns_q;

	logic [SW-1:0]   sec_max;
	logic [PW-1:0]   arg_ext;
	logic [PW-1:0]   scaled;
	logic [SW-1:0]   scaled_val;
	logic [29:0]     frac_add;
	logic [29:0]     frac_ns_nx;
	logic [30:0]     ns_sum;
	logic            ns_carry;
	logic [29:0]     ns_new;
	logic [SW:0]     sec_sum;
	logic [SW-1:0]   sec_new;
	logic [63:0]     sec_wide;
	logic            is_end;
	logic            is_digit;

	assign sec_max  = {SW{1'b1}};
	assign is_end   = (tok.kind == durp_pkg::TK_END);
	assign is_digit = (tok.kind == durp_pkg::TK_DIGIT);
	assign tok_pop  = tok_valid && !res_full;

	// Integer part: a digit is a multiply by ten and add, a suffix is a
	// constant scale. Both are shift-add forms with overflow seen in the
	// upper bits of the extended product.
	always_comb begin
		arg_ext = PW'(arg_sec_q);
		case (tok.kind)
			durp_pkg::TK_DIGIT: scaled = (arg_ext << 3) + (arg_ext << 1) + PW'(tok.digit);
			durp_pkg::TK_MIN:   scaled = (arg_ext << 6) - (arg_ext << 2);
			durp_pkg::TK_HOUR:  scaled = (arg_ext << 12) - (arg_ext << 9) + (arg_ext << 4);
			durp_pkg::TK_DAY:   scaled = (arg_ext << 16) + (arg_ext << 14) + (arg_ext << 12)
				+ (arg_ext << 8) + (arg_ext << 7);
			default:            scaled = arg_ext;
		endcase
		scaled_val = (|scaled[PW-1:SW]) ? sec_max : scaled[SW-1:0];
	end

	// Fraction digits are weighted into nanoseconds as they arrive.
	always_comb begin
		frac_add   = 30'(30'(tok.digit) * 30'(durp_pkg::frac_weight(frac_dig_q)));
		frac_ns_nx = frac_ns_q + frac_add;
	end

	// Terminator arithmetic: nanosecond sum with one carry into the
	// saturating seconds sum.
	always_comb begin
		ns_sum   = {1'b0, sum_ns_q} + {1'b0, frac_ns_q};
		ns_carry = (ns_sum >= {1'b0, durp_pkg::NS_PER_SEC});
		ns_new   = ns_carry ? 30'(ns_sum - {1'b0, durp_pkg::NS_PER_SEC}) : ns_sum[29:0];
		sec_sum  = {1'b0, sum_sec_q} + {1'b0, arg_sec_q} + (SW+1)'(ns_carry);
		sec_new  = sec_sum[SW] ? sec_max : sec_sum[SW-1:0];
		sec_wide = 64'(sec_new);
	end

	// Result generation.
	always_comb begin
		res_push               = 1'b0;
		res_data.total_seconds = '0;
		res_data.total_nanos   = '0;
		res_data.status        = durp_pkg::ST_OK;
		if (phase_q != PH_DISCARD) begin
			if (is_end) begin
				if (at_start_q) begin
					res_push        = 1'b1;
					res_data.status = durp_pkg::ST_EMPTY;
				end else if (tok.fin) begin
					res_push               = 1'b1;
					res_data.total_seconds = sec_wide[47:0];
					res_data.total_nanos   = ns_new;
				end
			end else if (phase_q == PH_INT && tok.kind == durp_pkg::TK_BAD) begin
				res_push        = 1'b1;
				res_data.status = durp_pkg::ST_SUFFIX;
			end else if (phase_q == PH_FRAC && !is_digit) begin
				res_push        = 1'b1;
				res_data.status = durp_pkg::ST_FRACTION;
			end
		end
		res_push = res_push && tok_pop;
	end

	// While discarding, at_start_q is not looked at; leaving the discard
	// phase sets it again for the next argument list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_INT;
			at_start_q <= 1'b1;
			arg_sec_q  <= '0;
			frac_ns_q  <= '0;
			frac_dig_q <= '0;
			sum_sec_q  <= '0;
			sum_ns_q   <= '0;
		end else if (tok_pop) begin
			if (phase_q == PH_DISCARD) begin
				if (is_end && tok.fin) begin
					phase_q    <= PH_INT;
					at_start_q <= 1'b1;
				end
			end else if (is_end) begin
				phase_q    <= (at_start_q && !tok.fin) ? PH_DISCARD : PH_INT;
				at_start_q <= 1'b1;
				arg_sec_q  <= '0;
				frac_ns_q  <= '0;
				frac_dig_q <= '0;
				if (at_start_q || tok.fin) begin
					sum_sec_q <= '0;
					sum_ns_q  <= '0;
				end else begin
					sum_sec_q <= sec_new;
					sum_ns_q  <= ns_new;
				end
			end else begin
				at_start_q <= 1'b0;
				case (phase_q)
					PH_INT: begin
						case (tok.kind)
							durp_pkg::TK_DIGIT: begin
								arg_sec_q <= scaled_val;
							end
							durp_pkg::TK_DAY, durp_pkg::TK_HOUR, durp_pkg::TK_MIN: begin
								arg_sec_q <= scaled_val;
								phase_q   <= PH_SKIP;
							end
							durp_pkg::TK_SEC: begin
								phase_q <= PH_SKIP;
							end
							durp_pkg::TK_DOT: begin
								phase_q <= PH_FRAC;
							end
							default: begin
								phase_q    <= PH_DISCARD;
								arg_sec_q  <= '0;
								frac_ns_q  <= '0;
								frac_dig_q <= '0;
								sum_sec_q  <= '0;
								sum_ns_q   <= '0;
							end
						endcase
					end
					PH_FRAC: begin
						if (!is_digit) begin
							phase_q    <= PH_DISCARD;
							arg_sec_q  <= '0;
							frac_ns_q  <= '0;
							frac_dig_q <= '0;
							sum_sec_q  <= '0;
							sum_ns_q   <= '0;
						end else if (frac_dig_q < 4'(durp_pkg::FRAC_MAX)) begin
							frac_ns_q  <= frac_ns_nx;
							frac_dig_q <= frac_dig_q + 4'd1;
						end
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/duration_spec_parser_top.sv -----
// Top level of the duration argument parser: front classifier, token queue,
// execution back end and result queue. Depends on durp_pkg and the durp_* modules.
//
//   Channel   Handshake           Payload                     Direction
//   ------    ---------           -------                     ---------
//   input     push / full         item   (durp_pkg::in_item_t)   into block
//   result    pop  / empty        result (durp_pkg::out_item_t)  out of block
//
// The block takes one character transaction per cycle, sustained, as long as
// results are drained. A result becomes visible after the terminating
// character that causes it is accepted: the token is registered in the token
// queue, and the back end, whose state update sets the rate, writes the result
// into the result queue, where it is registered; a full result queue stalls it.
// Reset (arst_n low) clears both queues and returns the parser to the start
// of a fresh argument list with zero totals.
// When the result queue fills, the back end stops taking tokens; the token
// queue then fills and full rises, so neither side loses a transaction.

module duration_spec_parser_top #(
	parameter int SECONDS_WIDTH = 48,
	parameter int TOK_DEPTH     = 4,
	parameter int RES_DEPTH     = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  durp_pkg::in_item_t  item,
	input  logic                pop,
	output logic                empty,
	output durp_pkg::out_item_t result
);

	durp_pkg::token_t    tok_in;
	durp_pkg::token_t    tok_out;
	logic                tok_empty;
	logic                tok_pop;
	logic                res_push;
	logic                res_full;
	durp_pkg::out_item_t res_data;

	// The front end sorts each character into a token class so the back end
	// only has to decide on a small code.
	durp_front u_front (
		.item (item),
		.tok  (tok_in)
	);

	// The token queue decouples acceptance from execution.
	durp_fifo #(
		.T     (durp_pkg::token_t),
		.DEPTH (TOK_DEPTH)
	) u_tok_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (tok_in),
		.full    (full),
		.rd_en   (tok_pop),
		.rd_data (tok_out),
		.empty   (tok_empty)
	);

	// The back end pops one token per cycle while res_full is low; one result at most.
	durp_back #(
		.SECONDS_WIDTH (SECONDS_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok_out),
		.tok_valid (!tok_empty),
		.tok_pop   (tok_pop),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_full  (res_full)
	);

	// The result queue holds finished transactions until they are popped.
	durp_fifo #(
		.T     (durp_pkg::out_item_t),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

// ----- tb/sv/duration_spec_parser_top_tb.sv -----
// Self-checking testbench for duration_spec_parser_top: feeds argument strings one
// character per transaction and checks every total against an in-bench predictor.
// Depends on durp_pkg and the duration_spec_parser_top RTL only.

module duration_spec_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Characters that steer the parser. The terminator ends an argument.
	localparam logic [7:0] CH_END  = 8'h00;
	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_NINE = "9";
	localparam logic [7:0] CH_DAY  = "d";
	localparam logic [7:0] CH_HOUR = "h";
	localparam logic [7:0] CH_MIN  = "m";
	localparam logic [7:0] CH_SEC  = "s";
	localparam logic [7:0] CH_DOT  = ".";

	// Largest whole-second count for the default SECONDS_WIDTH of 48.
	localparam logic [63:0] SEC_LIMIT = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0] NS_WRAP   = 64'd1000000000;

	// Length of the long result hold-off that forces both queues to fill.
	localparam int HOLD_CYCLES = 300;

	// Where the parser stands inside the current argument.
	typedef enum logic [1:0] {
		PARSE_INT,
		PARSE_FRAC,
		PARSE_SKIP,
		PARSE_DROP
	} parse_phase_t;

	// How a generated argument is spoiled, if at all.
	typedef enum int {
		FLAW_NONE,
		FLAW_EMPTY,
		FLAW_SUFFIX,
		FLAW_FRACTION
	} arg_flaw_t;

	// The predictor: it tracks the parser state on every accepted character
	// transaction and keeps the totals that the block still owes us.
	class duration_totals_board;
		parse_phase_t        phase;
		bit                  at_start;
		logic [63:0]         arg_secs;
		logic [63:0]         frac_val;
		int unsigned         frac_cnt;
		logic [63:0]         sum_secs;
		logic [63:0]         sum_ns;
		durp_pkg::out_item_t totals_q[$];
		int unsigned         mismatches;
		int unsigned         status_count[4];

		function new();
			restart();
			mismatches = 0;
			foreach (status_count[i])
				status_count[i] = 0;
		endfunction

		function void clear_arg();
			phase    = PARSE_INT;
			at_start = 1'b1;
			arg_secs = '0;
			frac_val = '0;
			frac_cnt = 0;
		endfunction

		function void restart();
			clear_arg();
			sum_secs = '0;
			sum_ns   = '0;
		endfunction

		function logic [63:0] mul_clamped(logic [63:0] a, logic [63:0] k);
			if (a > SEC_LIMIT / k)
				return SEC_LIMIT;
			return a * k;
		endfunction

		function logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
			if (b > SEC_LIMIT - a)
				return SEC_LIMIT;
			return a + b;
		endfunction

		function void owe_total(logic [63:0] secs, logic [63:0] ns, logic [1:0] st);
			durp_pkg::out_item_t t;
			t.total_seconds = secs[47:0];
			t.total_nanos   = ns[29:0];
			t.status        = st;
			totals_q.push_back(t);
		endfunction

		// An error zeroes the totals and, unless it came on the last
		// terminator, drops everything up to that terminator.
		function void owe_error(logic [1:0] st, bit fin);
			restart();
			if (!fin)
				phase = PARSE_DROP;
			owe_total('0, '0, st);
		endfunction

		function void note_char(durp_pkg::in_item_t it);
			logic [63:0] dval;
			logic [63:0] scale;
			bit          is_digit;
			is_digit = it.ch >= CH_ZERO && it.ch <= CH_NINE;
			dval     = 64'(it.ch - CH_ZERO);
			if (phase == PARSE_DROP) begin
				if (it.ch == CH_END && it.final_req)
					restart();
				return;
			end
			if (it.ch == CH_END) begin
				if (at_start) begin
					owe_error(durp_pkg::ST_EMPTY, it.final_req);
					return;
				end
				// Scale the kept fraction digits up to nanoseconds.
				scale = 64'd1;
				repeat (9 - frac_cnt)
					scale = scale * 64'd10;
				sum_ns = sum_ns + frac_val * scale;
				if (sum_ns >= NS_WRAP) begin
					sum_ns   = sum_ns - NS_WRAP;
					sum_secs = add_clamped(add_clamped(sum_secs, arg_secs), 64'd1);
				end else begin
					sum_secs = add_clamped(sum_secs, arg_secs);
				end
				clear_arg();
				if (it.final_req) begin
					owe_total(sum_secs, sum_ns, durp_pkg::ST_OK);
					restart();
				end
				return;
			end
			at_start = 1'b0;
			case (phase)
				PARSE_INT: begin
					if (is_digit) begin
						arg_secs = add_clamped(mul_clamped(arg_secs, 64'd10), dval);
					end else if (it.ch == CH_DAY) begin
						arg_secs = mul_clamped(mul_clamped(mul_clamped(arg_secs, 64'd24),
							64'd60), 64'd60);
						phase = PARSE_SKIP;
					end else if (it.ch == CH_HOUR) begin
						arg_secs = mul_clamped(mul_clamped(arg_secs, 64'd60), 64'd60);
						phase = PARSE_SKIP;
					end else if (it.ch == CH_MIN) begin
						arg_secs = mul_clamped(arg_secs, 64'd60);
						phase = PARSE_SKIP;
					end else if (it.ch == CH_SEC) begin
						phase = PARSE_SKIP;
					end else if (it.ch == CH_DOT) begin
						phase = PARSE_FRAC;
					end else begin
						owe_error(durp_pkg::ST_SUFFIX, 1'b0);
					end
				end
				PARSE_FRAC: begin
					if (!is_digit) begin
						owe_error(durp_pkg::ST_FRACTION, 1'b0);
					end else if (frac_cnt < 9) begin
						// Digits past the ninth are checked but do not count.
						frac_val = frac_val * 64'd10 + dval;
						frac_cnt++;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_total(durp_pkg::out_item_t got);
			durp_pkg::out_item_t want;
			if (totals_q.size() == 0) begin
				$error("unexpected result transaction: seconds %0d, nanos %0d, status %0d",
					got.total_seconds, got.total_nanos, got.status);
				mismatches++;
				return;
			end
			want = totals_q.pop_front();
			status_count[want.status]++;
			if (got.total_seconds !== want.total_seconds) begin
				$error("total_seconds: expected %0d, actual %0d",
					want.total_seconds, got.total_seconds);
				mismatches++;
			end
			if (got.total_nanos !== want.total_nanos) begin
				$error("total_nanos: expected %0d, actual %0d",
					want.total_nanos, got.total_nanos);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	durp_pkg::in_item_t  item;
	logic                pop;
	logic                empty;
	durp_pkg::out_item_t result;

	duration_spec_parser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	duration_totals_board board = new();

	// Characters waiting to be offered, and counts used to tell when the
	// block has taken every one of them.
	durp_pkg::in_item_t char_q[$];
	int unsigned        chars_queued;
	int unsigned        chars_accepted;

	// When steady is set neither side idles. hold_results asks the
	// receiver for one long hold-off.
	bit steady;
	bit hold_results;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Every input has a known value from time zero. Reset is applied once
	// and released on a falling edge.
	initial begin
		arst_n = 1'b0;
		push   = 1'b0;
		pop    = 1'b0;
		item   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Hard stop in case the block hangs. It allows far more time than the
	// slowest correct run takes.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// Both handshakes are sampled on the rising edge, where the values that
	// the drivers set on the previous falling edge are stable.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				board.note_char(item);
				chars_accepted++;
			end
			if (pop && !empty)
				board.check_total(result);
		end
	end

	// Sender: on each falling edge it either idles or offers the next
	// character and holds it until a rising edge sees full low.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (char_q.size() == 0 || (!steady && $urandom_range(0, 99) < 14)) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				item <= char_q.pop_front();
				@(posedge clk);
				while (full)
					@(posedge clk);
			end
		end
	end

	// Receiver: pops at random, except for one long hold-off that it counts
	// itself while the sender keeps offering characters.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_results = 1'b0;
			end
			pop <= steady || ($urandom_range(0, 99) >= 14);
		end
	end

	task automatic put_char(logic [7:0] c, bit fin);
		durp_pkg::in_item_t it;
		it.ch        = c;
		it.final_req = fin;
		char_q.push_back(it);
		chars_queued++;
	endtask

	// Non-terminating characters carry a random final flag, which the block
	// must ignore.
	task automatic put_text_char(logic [7:0] c);
		put_char(c, $urandom_range(0, 3) == 0);
	endtask

	task automatic put_word(string s);
		for (int i = 0; i < s.len(); i++)
			put_text_char(s[i]);
	endtask

	task automatic put_digits(int n, bit nines);
		logic [7:0] c;
		repeat (n) begin
			c = CH_ZERO + 8'($urandom_range(0, 9));
			put_text_char(nines ? CH_NINE : c);
		end
	endtask

	function automatic logic [7:0] pick_non_digit(bit also_suffix);
		logic [7:0] c;
		bit         legal;
		do begin
			c     = 8'($urandom_range(1, 255));
			legal = (c >= CH_ZERO && c <= CH_NINE) || (also_suffix && (c == CH_DAY ||
				c == CH_HOUR || c == CH_MIN || c == CH_SEC || c == CH_DOT));
		end while (legal);
		return c;
	endfunction

	// One argument: an integer part of mostly short length, but sometimes
	// long enough to hit the seconds limit, then a suffix, a fraction or
	// nothing, and the terminator. A flaw empties it or spoils its suffix or fraction.
	task automatic queue_argument(bit last, arg_flaw_t flaw);
		int         r;
		int         n_int;
		int         form;
		logic [7:0] junk;
		r = $urandom_range(0, 99);
		if (flaw == FLAW_EMPTY) begin
			put_char(CH_END, last);
			return;
		end
		n_int = (r < 5) ? 0 : (r < 75) ? $urandom_range(1, 6) :
			(r < 92) ? $urandom_range(7, 15) : $urandom_range(16, 20);
		put_digits(n_int, $urandom_range(0, 9) == 0);
		form = $urandom_range(0, 9);
		if (flaw == FLAW_SUFFIX) begin
			put_text_char(pick_non_digit(1'b1));
			put_digits($urandom_range(0, 2), 1'b0);
		end else if (flaw == FLAW_FRACTION) begin
			put_text_char(CH_DOT);
			put_digits($urandom_range(0, 3), 1'b0);
			put_text_char(pick_non_digit(1'b0));
		end else if (form >= 6 || n_int == 0) begin
			put_text_char(CH_DOT);
			put_digits($urandom_range(0, 12), $urandom_range(0, 3) == 0);
		end else if (form >= 2) begin
			case (form)
				2:       put_text_char(CH_DAY);
				3:       put_text_char(CH_HOUR);
				4:       put_text_char(CH_MIN);
				default: put_text_char(CH_SEC);
			endcase
			// Anything after a suffix is skipped up to the terminator.
			if ($urandom_range(0, 9) < 3) begin
				repeat ($urandom_range(1, 3)) begin
					junk = 8'($urandom_range(1, 255));
					put_text_char(junk);
				end
			end
		end
		put_char(CH_END, last);
	endtask

	// A list of arguments closed by a final terminator. Most lists are well
	// formed; some carry one spoiled argument, and a few are plain noise.
	task automatic queue_list();
		int         r;
		int         n_args;
		int         bad_at;
		arg_flaw_t  flaw;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			repeat ($urandom_range(1, 12)) begin
				c = 8'($urandom_range(0, 255));
				put_char(c, 1'($urandom_range(0, 1)));
			end
			return;
		end
		n_args = $urandom_range(1, 4);
		bad_at = (r < 24) ? $urandom_range(0, n_args - 1) : -1;
		for (int i = 0; i < n_args; i++) begin
			flaw = FLAW_NONE;
			if (i == bad_at)
				flaw = arg_flaw_t'($urandom_range(FLAW_EMPTY, FLAW_FRACTION));
			queue_argument(i == n_args - 1, flaw);
		end
	endtask

	task automatic queue_random(int n_chars);
		int unsigned target;
		target = chars_queued + n_chars;
		while (chars_queued < target)
			queue_list();
	endtask

	// Wait until every queued character is in and every owed total is out.
	task automatic drain();
		while (chars_accepted != chars_queued || board.totals_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		chars_queued   = 0;
		chars_accepted = 0;
		steady         = 1'b0;
		hold_results   = 1'b0;
		wait (arst_n === 1'b1);

		// Directed part. An empty last argument reports at once.
		put_char(CH_END, 1'b1);
		// An empty argument that is not the last one reports and then drops
		// input through the final terminator.
		put_char(CH_END, 1'b0);
		put_char(CH_END, 1'b1);
		// Every suffix, text after a suffix, and a bare fraction.
		put_word("1d");
		put_char(CH_END, 1'b0);
		put_word("2h");
		put_char(CH_END, 1'b0);
		put_word("3m");
		put_char(CH_END, 1'b0);
		put_word("4sz");
		put_char(CH_END, 1'b0);
		put_word(".5");
		put_char(CH_END, 1'b1);
		// A bad suffix, then a bad fraction character.
		put_word("9x");
		put_char(CH_END, 1'b1);
		put_word(".a");
		put_char(CH_END, 1'b1);
		drain();

		// Random part, first with a long result hold-off at its start so
		// that the result queue and then the token queue fill up.
		@(posedge clk);
		hold_results = 1'b1;
		queue_random(400);
		drain();

		// A stretch where neither side ever idles.
		@(posedge clk);
		steady = 1'b1;
		queue_random(350);
		drain();
		@(posedge clk);
		steady = 1'b0;

		queue_random(350);
		drain();

		// Wait on in case the block produces a result it should not.
		repeat (20) @(posedge clk);

		$display("Sent %0d characters; checked %0d good totals and %0d/%0d/%0d errors",
			chars_accepted, board.status_count[durp_pkg::ST_OK],
			board.status_count[durp_pkg::ST_EMPTY],
			board.status_count[durp_pkg::ST_SUFFIX],
			board.status_count[durp_pkg::ST_FRACTION]);
		$display("(empty argument / bad suffix / bad fraction).");
		if (board.mismatches == 0 && board.totals_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
